// File: sv/hwm_pkg.sv
// ----------------------------------------------------------------------------
// Heightfield window minimum package
// Shared widths, sizes and configuration register indexes.
// ----------------------------------------------------------------------------
package hwm_pkg;

    // Field geometry
    localparam int MAX_LOG2_SIZE = 8;
    localparam int MAX_RADIUS    = 7;
    localparam int COORD_W       = MAX_LOG2_SIZE;
    localparam int ADDR_W        = 2 * MAX_LOG2_SIZE;
    localparam int DEPTH         = 1 << ADDR_W;
    localparam int SAMPLE_W      = 16;

    // Configuration port
    localparam int LOG2_W        = 4;
    localparam int RADIUS_W      = 3;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 4;
    localparam int STEP_W        = RADIUS_W + 1;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LOG2_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOG2_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_X    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_Y    = 2'd3;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [COORD_W-1:0]         coord_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// File: sv/heightfield_window_minimum.sv
// ----------------------------------------------------------------------------
// Heightfield window minimum
// Sample store with a wrapping 2-D minimum filter over one shared read port.
// ----------------------------------------------------------------------------
// A write transaction stores one sample in the cycle it is accepted and leaves
// busy low, so writes can follow back to back. A query transaction raises busy
// and walks the window through the single read port of the sample store, one
// sample per cycle, into one signed compare unit. The result is shown for
// exactly one cycle on result_valid and cannot be held off, and busy is already
// low in that cycle. Configuration is to be written only while idle: that binds
// the user, and the block itself does not enforce it.
module heightfield_window_minimum (
    input  logic                               clk,
    input  logic                               rst_n,
    // Command channel
    input  logic                               start,
    output logic                               busy,
    input  logic                               opcode,
    input  logic [hwm_pkg::COORD_W-1:0]        pos_x,
    input  logic [hwm_pkg::COORD_W-1:0]        pos_y,
    input  logic signed [hwm_pkg::SAMPLE_W-1:0] sample,
    // Configuration port
    input  logic                               cfg_we,
    input  logic [hwm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hwm_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Result channel
    output logic                               result_valid,
    output logic [hwm_pkg::COORD_W-1:0]        out_x,
    output logic [hwm_pkg::COORD_W-1:0]        out_y,
    output logic signed [hwm_pkg::SAMPLE_W-1:0] min_value
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    // Configuration registers
    logic [hwm_pkg::LOG2_W-1:0]   log2_width_reg;
    logic [hwm_pkg::LOG2_W-1:0]   log2_height_reg;
    logic [hwm_pkg::RADIUS_W-1:0] radius_x_reg;
    logic [hwm_pkg::RADIUS_W-1:0] radius_y_reg;

    // Sequencer and datapath
    logic [1:0]                 state_reg, state_next;
    hwm_pkg::coord_t            x_reg, y_reg;
    hwm_pkg::coord_t            mask_x_reg, mask_y_reg;
    logic [hwm_pkg::RADIUS_W-1:0] rx_reg, ry_reg;
    logic [hwm_pkg::STEP_W-1:0] k_reg, k_next;
    logic [hwm_pkg::STEP_W-1:0] l_reg, l_next;
    hwm_pkg::sample_t           best_reg, best_next;
    logic                       rd_vld_reg, rd_last_reg;
    hwm_pkg::sample_t           rdata_reg;
    logic                       result_valid_reg;
    hwm_pkg::coord_t            out_x_reg, out_y_reg;
    hwm_pkg::sample_t           min_value_reg;

    hwm_pkg::sample_t           mem [hwm_pkg::DEPTH];

    logic                       accept;
    logic [hwm_pkg::LOG2_W-1:0] lw_clamp, lh_clamp;
    logic [hwm_pkg::COORD_W:0]  mask_x_wide, mask_y_wide;
    hwm_pkg::coord_t            mask_x, mask_y;
    hwm_pkg::coord_t            in_x, in_y;
    logic [hwm_pkg::RADIUS_W-1:0] rx_clamp, ry_clamp;
    logic [hwm_pkg::STEP_W-1:0] k_end, l_end;
    hwm_pkg::coord_t            cx, cy;
    logic                       scan_last;

    assign accept = start && !busy;

    // Clamp the field size and derive the wrap masks
    always_comb
    begin
        lw_clamp = log2_width_reg;
        if (log2_width_reg == '0)
            lw_clamp = hwm_pkg::LOG2_W'(1);
        else if (log2_width_reg > hwm_pkg::LOG2_W'(hwm_pkg::MAX_LOG2_SIZE))
            lw_clamp = hwm_pkg::LOG2_W'(hwm_pkg::MAX_LOG2_SIZE);
        lh_clamp = log2_height_reg;
        if (log2_height_reg == '0)
            lh_clamp = hwm_pkg::LOG2_W'(1);
        else if (log2_height_reg > hwm_pkg::LOG2_W'(hwm_pkg::MAX_LOG2_SIZE))
            lh_clamp = hwm_pkg::LOG2_W'(hwm_pkg::MAX_LOG2_SIZE);
        mask_x_wide = ((hwm_pkg::COORD_W+1)'(1) << lw_clamp) - (hwm_pkg::COORD_W+1)'(1);
        mask_y_wide = ((hwm_pkg::COORD_W+1)'(1) << lh_clamp) - (hwm_pkg::COORD_W+1)'(1);
        mask_x = mask_x_wide[hwm_pkg::COORD_W-1:0];
        mask_y = mask_y_wide[hwm_pkg::COORD_W-1:0];
        in_x   = pos_x & mask_x;
        in_y   = pos_y & mask_y;
    end

    // Clamp the radii to the supported range
    always_comb
    begin
        rx_clamp = (radius_x_reg == '0) ? hwm_pkg::RADIUS_W'(1) : radius_x_reg;
        ry_clamp = (radius_y_reg == '0) ? hwm_pkg::RADIUS_W'(1) : radius_y_reg;
        if (rx_clamp > hwm_pkg::RADIUS_W'(hwm_pkg::MAX_RADIUS))
            rx_clamp = hwm_pkg::RADIUS_W'(hwm_pkg::MAX_RADIUS);
        if (ry_clamp > hwm_pkg::RADIUS_W'(hwm_pkg::MAX_RADIUS))
            ry_clamp = hwm_pkg::RADIUS_W'(hwm_pkg::MAX_RADIUS);
    end

    // Window coordinate of the current read, wrapped to the field
    always_comb
    begin
        k_end     = {rx_reg, 1'b0};
        l_end     = {ry_reg, 1'b0};
        cx        = (x_reg + hwm_pkg::COORD_W'(k_reg) - hwm_pkg::COORD_W'(rx_reg)) & mask_x_reg;
        cy        = (y_reg + hwm_pkg::COORD_W'(l_reg) - hwm_pkg::COORD_W'(ry_reg)) & mask_y_reg;
        scan_last = (k_reg == k_end) && (l_reg == l_end);
    end

    // Sequencer: step the window counters and fold returning samples
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        l_next     = l_reg;
        best_next  = best_reg;
        if (rd_vld_reg && (rdata_reg < best_reg))
            best_next = rdata_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (opcode == hwm_pkg::OP_QUERY))
                begin
                    state_next = S_SCAN;
                    k_next     = '0;
                    l_next     = '0;
                    best_next  = {1'b0, {(hwm_pkg::SAMPLE_W-1){1'b1}}};
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                    state_next = S_WAIT;
                if (l_reg == l_end)
                begin
                    l_next = '0;
                    k_next = k_reg + hwm_pkg::STEP_W'(1);
                end
                else
                begin
                    l_next = l_reg + hwm_pkg::STEP_W'(1);
                end
            end
            S_WAIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sample store: write on a write transaction, read while scanning
    always_ff @(posedge clk)
    begin
        if (accept && (opcode == hwm_pkg::OP_WRITE))
            mem[{in_y, in_x}] <= sample;
        rdata_reg <= mem[{cy, cx}];
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_width_reg  <= hwm_pkg::LOG2_W'(8);
            log2_height_reg <= hwm_pkg::LOG2_W'(8);
            radius_x_reg    <= hwm_pkg::RADIUS_W'(1);
            radius_y_reg    <= hwm_pkg::RADIUS_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hwm_pkg::REG_LOG2_WIDTH:  log2_width_reg  <= cfg_data;
                hwm_pkg::REG_LOG2_HEIGHT: log2_height_reg <= cfg_data;
                hwm_pkg::REG_RADIUS_X:    radius_x_reg    <= cfg_data[hwm_pkg::RADIUS_W-1:0];
                hwm_pkg::REG_RADIUS_Y:    radius_y_reg    <= cfg_data[hwm_pkg::RADIUS_W-1:0];
                default:                  log2_width_reg  <= log2_width_reg;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            rd_vld_reg       <= 1'b0;
            rd_last_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_vld_reg       <= (state_reg == S_SCAN);
            rd_last_reg      <= (state_reg == S_SCAN) && scan_last;
            result_valid_reg <= rd_last_reg;
        end
    end

    // Datapath registers: capture the query, advance counters, hold result
    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        l_reg    <= l_next;
        best_reg <= best_next;
        if (accept && (opcode == hwm_pkg::OP_QUERY))
        begin
            x_reg      <= in_x;
            y_reg      <= in_y;
            mask_x_reg <= mask_x;
            mask_y_reg <= mask_y;
            rx_reg     <= rx_clamp;
            ry_reg     <= ry_clamp;
        end
        if (rd_last_reg)
        begin
            out_x_reg     <= x_reg;
            out_y_reg     <= y_reg;
            min_value_reg <= best_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign min_value    = min_value_reg;

    // Checks
    a_result_after_wait: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> $past(state_reg == S_WAIT))
        else $error("result strobe without a finished scan");

    a_read_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(state_reg == S_SCAN))
        else $error("read data valid outside a scan");

    a_counter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ((k_reg <= k_end) && (l_reg <= l_end)))
        else $error("window counter beyond the window");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |=> !result_valid_reg)
        else $error("result strobe longer than one cycle");

endmodule
